// ===== rtl/ssbf_pkg.sv =====
// ssbf_pkg: types, widths and constants shared by the significant bin finder.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package ssbf_pkg;

    localparam int DATA_W       = 16;        // bin component width
    localparam int MAG_W        = 31;        // saturated squared magnitude
    localparam int RATIO_W      = 16;        // Q8.8 ratio
    localparam int M1_W         = MAG_W + RATIO_W;   // mag2 * ratio
    localparam int PROD_W       = M1_W + RATIO_W;    // mag2 * ratio^2
    localparam int IDX_W        = 12;        // reported index width
    localparam int ADDR_W       = 3;         // APB byte address
    localparam int QUEUE_DEPTH  = 8;         // words between front and back
    localparam int QLEVEL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FRONT_STAGES = 4;
    localparam int INFL_W       = $clog2(FRONT_STAGES + 1);
    localparam int MAX_BINS_DEFAULT = 4096;

    localparam logic [RATIO_W-1:0] DEFAULT_RATIO = 16'd25600;  // 100.0 in Q8.8
    localparam logic [MAG_W-1:0]   MAG_MAX       = {MAG_W{1'b1}};

    // register index, taken from paddr[2]
    localparam logic REG_THRESHOLD_RATIO = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] real_part;
        logic signed [DATA_W-1:0] imag_part;
        logic                     frame_last;
    } t_bin;

    typedef struct packed {
        logic [IDX_W-1:0] strongest_bin;
        logic [IDX_W-1:0] significant_bin;
    } t_result;

    // word passed from front to back
    typedef struct packed {
        logic [MAG_W-1:0]  mag2;
        logic [PROD_W-1:0] prod;
        logic              last;
    } t_work;

    typedef struct packed {
        logic                empty;
        logic [QLEVEL_W-1:0] level;
    } t_q_stat;

    typedef struct packed {
        logic take;      // back consumes a queue word this cycle
        logic emit;      // that word closes a frame
    } t_back_stat;

endpackage

// ===== rtl/ssbf_front.sv =====
// ssbf_front: four-stage magnitude and ratio product pipeline.
// Depends on ssbf_pkg. Never stalls; the top level grants entry by credit.
module ssbf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  ssbf_pkg::t_bin               i_bin,
    input  logic [ssbf_pkg::RATIO_W-1:0] i_ratio,
    output logic                         o_valid,
    output ssbf_pkg::t_work              o_work,
    output logic [ssbf_pkg::INFL_W-1:0]  o_inflight
);

    logic                         r_v1, r_v2, r_v3, r_v4;
    logic                         r_l1, r_l2, r_l3, r_l4;
    logic [ssbf_pkg::MAG_W-1:0]   r_sq_re, r_sq_im;
    logic [ssbf_pkg::MAG_W-1:0]   r_mag2, r_mag3, r_mag4;
    logic [ssbf_pkg::M1_W-1:0]    r_m1;
    logic [ssbf_pkg::PROD_W-1:0]  r_prod;

    logic signed [2*ssbf_pkg::DATA_W-1:0] sq_re, sq_im;
    logic [ssbf_pkg::MAG_W:0]             sum;
    logic [ssbf_pkg::MAG_W-1:0]           mag_sat;

    assign sq_re   = i_bin.real_part * i_bin.real_part;
    assign sq_im   = i_bin.imag_part * i_bin.imag_part;
    assign sum     = {1'b0, r_sq_re} + {1'b0, r_sq_im};
    // only both parts at full negative scale reach 2^31
    assign mag_sat = sum[ssbf_pkg::MAG_W] ? ssbf_pkg::MAG_MAX : sum[ssbf_pkg::MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_re <= sq_re[ssbf_pkg::MAG_W-1:0];
        r_sq_im <= sq_im[ssbf_pkg::MAG_W-1:0];
        r_l1    <= i_bin.frame_last;
        r_mag2  <= mag_sat;
        r_l2    <= r_l1;
        r_m1    <= ssbf_pkg::M1_W'(r_mag2 * i_ratio);
        r_mag3  <= r_mag2;
        r_l3    <= r_l2;
        r_prod  <= ssbf_pkg::PROD_W'(r_m1 * i_ratio);
        r_mag4  <= r_mag3;
        r_l4    <= r_l3;
    end

    assign o_valid      = r_v4;
    assign o_work.mag2  = r_mag4;
    assign o_work.prod  = r_prod;
    assign o_work.last  = r_l4;
    assign o_inflight   = ssbf_pkg::INFL_W'(r_v1) + ssbf_pkg::INFL_W'(r_v2)
                        + ssbf_pkg::INFL_W'(r_v3) + ssbf_pkg::INFL_W'(r_v4);

endmodule

// ===== rtl/ssbf_queue.sv =====
// ssbf_queue: short FIFO of work words between front and back.
// Depends on ssbf_pkg. Depth set by ssbf_pkg::QUEUE_DEPTH.
module ssbf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ssbf_pkg::t_work   i_work,
    input  logic              i_pop,
    output ssbf_pkg::t_work   o_work,
    output ssbf_pkg::t_q_stat o_stat
);

    ssbf_pkg::t_work                r_mem [ssbf_pkg::QUEUE_DEPTH];
    logic [ssbf_pkg::QPTR_W-1:0]    r_wr, r_rd;
    logic [ssbf_pkg::QLEVEL_W-1:0]  r_level;
    logic                           do_pop;

    assign do_pop = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == ssbf_pkg::QPTR_W'(ssbf_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == ssbf_pkg::QPTR_W'(ssbf_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    assign o_work       = r_mem[r_rd];
    assign o_stat.empty = (r_level == '0);
    assign o_stat.level = r_level;

endmodule

// ===== rtl/ssbf_back.sv =====
// ssbf_back: frame state (counter, peak, indices) and the result register.
// Depends on ssbf_pkg. One queue word per cycle; a closing word waits for a free result slot.
module ssbf_back #(
    parameter int MAX_BINS = ssbf_pkg::MAX_BINS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssbf_pkg::t_work      i_work,
    input  ssbf_pkg::t_q_stat    i_qstat,
    input  logic                 i_pop,
    output ssbf_pkg::t_back_stat o_stat,
    output logic                 o_empty,
    output ssbf_pkg::t_result    o_result
);

    localparam int CW = $clog2(MAX_BINS);

    logic [CW-1:0]              r_cnt, r_strong, r_sig;
    logic [ssbf_pkg::MAG_W-1:0] r_peak;
    logic                       r_out_valid;
    ssbf_pkg::t_result          r_result;

    logic                       out_free, take, beats;
    logic [ssbf_pkg::MAG_W-1:0] n_peak;
    logic [CW-1:0]              n_strong, n_sig;
    logic [ssbf_pkg::PROD_W-1:0] thresh;

    assign out_free = !r_out_valid || i_pop;
    assign take     = !i_qstat.empty && (!i_work.last || out_free);
    assign beats    = i_work.mag2 > r_peak;
    assign n_peak   = beats ? i_work.mag2 : r_peak;
    assign n_strong = beats ? r_cnt : r_strong;
    // peak including this bin, scaled by 2^16 for the Q8.8 ratio squared
    assign thresh   = ssbf_pkg::PROD_W'({n_peak, 16'b0});
    assign n_sig    = (i_work.prod > thresh) ? r_cnt : r_sig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_peak      <= '0;
            r_strong    <= '0;
            r_sig       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && i_work.last) begin
                r_cnt    <= '0;
                r_peak   <= '0;
                r_strong <= '0;
                r_sig    <= '0;
            end else if (take) begin
                r_peak   <= n_peak;
                r_strong <= n_strong;
                r_sig    <= n_sig;
                if (r_cnt < CW'(MAX_BINS - 1)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (take && i_work.last) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_work.last) begin
            r_result.strongest_bin   <= ssbf_pkg::IDX_W'(n_strong);
            r_result.significant_bin <= ssbf_pkg::IDX_W'(n_sig);
        end
    end

    assign o_stat.take = take;
    assign o_stat.emit = take && i_work.last;
    assign o_empty     = !r_out_valid;
    assign o_result    = r_result;

endmodule

// ===== rtl/spectral_significant_bin_finder.sv =====
// spectral_significant_bin_finder: top level, APB register and credit logic.
// Depends on ssbf_pkg, ssbf_front, ssbf_queue and ssbf_back.
//
// Usage
//  - Bins enter as words on i_bin (push/full). A word is taken at an edge with
//    push high and full low. frame_last marks the closing bin of a frame.
//  - One result word per frame leaves on o_result (empty/pop): strongest bin
//    and highest significant bin, taken at an edge with pop high, empty low.
//  - threshold_ratio (Q8.8, zero means 100) sits at APB byte address 0; write
//    it only while the block is idle. Reads return it.
// Throughput: one bin per cycle sustained while results are popped in time. The
//  front multiplier pipeline and the back compare each handle one word a cycle.
// Path: a closing bin passes the 4 front stages, the queue write and the result
//  register before its result word shows on o_result.
// full rises when the 8-word queue plus the 4 front stages hold 8 words; the
//  front uses credits so it never stalls.
// Stall: while a result waits unpopped, the back keeps taking non-closing
//  bins; only the next closing bin waits, and the queue then fills to full.
// Reset (synchronous, i_rst_n low) clears frame state, queue, pipeline and
//  the register; no clearing pass is needed.
module spectral_significant_bin_finder #(
    parameter int MAX_BINS = ssbf_pkg::MAX_BINS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssbf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  ssbf_pkg::t_bin              i_bin,
    output logic                        empty,
    input  logic                        pop,
    output ssbf_pkg::t_result           o_result
);

    logic [ssbf_pkg::RATIO_W-1:0]  r_ratio;
    logic [ssbf_pkg::RATIO_W-1:0]  ratio_eff;
    logic                          cfg_wr, in_accept;
    logic                          f_valid, q_pop;
    ssbf_pkg::t_work               f_work, q_work;
    ssbf_pkg::t_q_stat             q_stat;
    ssbf_pkg::t_back_stat          b_stat;
    logic [ssbf_pkg::INFL_W-1:0]   inflight;
    logic [ssbf_pkg::QLEVEL_W:0]   occupancy;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= '0;
        end else if (cfg_wr && (paddr[2] == ssbf_pkg::REG_THRESHOLD_RATIO)) begin
            r_ratio <= pwdata[ssbf_pkg::RATIO_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ssbf_pkg::REG_THRESHOLD_RATIO)
                  ? {{(32 - ssbf_pkg::RATIO_W){1'b0}}, r_ratio} : 32'd0;

    assign ratio_eff = (r_ratio == '0) ? ssbf_pkg::DEFAULT_RATIO : r_ratio;

    // credit: words in queue plus words still in the front pipeline
    assign occupancy = (ssbf_pkg::QLEVEL_W + 1)'(q_stat.level)
                     + (ssbf_pkg::QLEVEL_W + 1)'(inflight);
    assign full      = occupancy >= (ssbf_pkg::QLEVEL_W + 1)'(ssbf_pkg::QUEUE_DEPTH);
    assign in_accept = push && !full;

    ssbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_bin      (i_bin),
        .i_ratio    (ratio_eff),
        .o_valid    (f_valid),
        .o_work     (f_work),
        .o_inflight (inflight)
    );

    ssbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_work  (f_work),
        .i_pop   (q_pop),
        .o_work  (q_work),
        .o_stat  (q_stat)
    );

    assign q_pop = b_stat.take;

    ssbf_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_work   (q_work),
        .i_qstat  (q_stat),
        .i_pop    (pop),
        .o_stat   (b_stat),
        .o_empty  (empty),
        .o_result (o_result)
    );

    // the credit scheme must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> (q_stat.level < ssbf_pkg::QLEVEL_W'(ssbf_pkg::QUEUE_DEPTH)))
        else $error("work queue overflow");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (ssbf_pkg::QLEVEL_W + 1)'(ssbf_pkg::QUEUE_DEPTH))
        else $error("queue plus pipeline exceed depth");

    // a closing bin always lands in the result register
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.emit |=> !empty)
        else $error("closed frame left no result");

    // a closing bin is taken only when the result slot is free
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.emit |-> (empty || pop))
        else $error("result overwritten before pop");

endmodule
